### rtl/m3inv_pkg.sv
// Shared types, constants and the multiply-accumulate program of the 3x3 matrix inverse.
package m3inv_pkg;

    localparam int CW = 65;
    localparam int DW = 99;
    localparam int QB = 33;
    localparam logic [4:0] LAST_STEP = 5'd23;

    typedef enum logic [1:0] {B_M, B_LO, B_HI} t_bsel;

    typedef struct packed {
        logic [3:0] a_idx;
        t_bsel      b_kind;
        logic [3:0] b_idx;
        logic       neg;
        logic       first;
        logic       wr;
        logic [3:0] c_idx;
    } t_op;

    typedef struct packed {
        logic [8:0][CW-1:0] cof;
        logic [DW-1:0]      det;
    } t_job;

    typedef enum logic [1:0] {F_IDLE, F_RUN, F_DRAIN, F_PUSH} t_fstate;
    typedef enum logic [2:0] {B_IDLE, B_LOAD, B_CHK, B_DIV, B_FIN, B_OUT} t_bstate;

    function automatic t_op mk(input logic [3:0] a, input t_bsel k, input logic [3:0] b,
                               input logic n, input logic f, input logic w,
                               input logic [3:0] c);
        t_op o;
        o.a_idx = a; o.b_kind = k; o.b_idx = b; o.neg = n; o.first = f; o.wr = w;
        o.c_idx = c;
        return o;
    endfunction

    function automatic t_op m3inv_op(input logic [4:0] step);
        t_op o;
        unique case (step)
            5'd0:  o = mk(4'd4, B_M, 4'd8, 1'b0, 1'b1, 1'b0, 4'd0);
            5'd1:  o = mk(4'd5, B_M, 4'd7, 1'b1, 1'b0, 1'b1, 4'd0);
            5'd2:  o = mk(4'd2, B_M, 4'd7, 1'b0, 1'b1, 1'b0, 4'd1);
            5'd3:  o = mk(4'd1, B_M, 4'd8, 1'b1, 1'b0, 1'b1, 4'd1);
            5'd4:  o = mk(4'd1, B_M, 4'd5, 1'b0, 1'b1, 1'b0, 4'd2);
            5'd5:  o = mk(4'd2, B_M, 4'd4, 1'b1, 1'b0, 1'b1, 4'd2);
            5'd6:  o = mk(4'd5, B_M, 4'd6, 1'b0, 1'b1, 1'b0, 4'd3);
            5'd7:  o = mk(4'd3, B_M, 4'd8, 1'b1, 1'b0, 1'b1, 4'd3);
            5'd8:  o = mk(4'd0, B_M, 4'd8, 1'b0, 1'b1, 1'b0, 4'd4);
            5'd9:  o = mk(4'd2, B_M, 4'd6, 1'b1, 1'b0, 1'b1, 4'd4);
            5'd10: o = mk(4'd2, B_M, 4'd3, 1'b0, 1'b1, 1'b0, 4'd5);
            5'd11: o = mk(4'd0, B_M, 4'd5, 1'b1, 1'b0, 1'b1, 4'd5);
            5'd12: o = mk(4'd3, B_M, 4'd7, 1'b0, 1'b1, 1'b0, 4'd6);
            5'd13: o = mk(4'd4, B_M, 4'd6, 1'b1, 1'b0, 1'b1, 4'd6);
            5'd14: o = mk(4'd1, B_M, 4'd6, 1'b0, 1'b1, 1'b0, 4'd7);
            5'd15: o = mk(4'd0, B_M, 4'd7, 1'b1, 1'b0, 1'b1, 4'd7);
            5'd16: o = mk(4'd0, B_M, 4'd4, 1'b0, 1'b1, 1'b0, 4'd8);
            5'd17: o = mk(4'd1, B_M, 4'd3, 1'b1, 1'b0, 1'b1, 4'd8);
            5'd18: o = mk(4'd0, B_LO, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0);
            5'd19: o = mk(4'd0, B_HI, 4'd0, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd20: o = mk(4'd1, B_LO, 4'd3, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd21: o = mk(4'd1, B_HI, 4'd3, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd22: o = mk(4'd2, B_LO, 4'd6, 1'b0, 1'b0, 1'b0, 4'd0);
            5'd23: o = mk(4'd2, B_HI, 4'd6, 1'b0, 1'b0, 1'b0, 4'd0);
            default: o = mk(4'd0, B_M, 4'd0, 1'b0, 1'b0, 1'b0, 4'd0);
        endcase
        return o;
    endfunction

endpackage

### rtl/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse: front end, job queue and divider.
// The front end takes one item at a time on its single 33x33 multiplier.
// The divider sets the throughput: it takes one item at a time, one entry after another.
// Two computed items may wait in the queue, so start is taken while the divider works.
// Reset is synchronous and active low and clears all control state; results are a strobe.
module matrix3_inverse
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_m00, i_m01, i_m02,
    input  logic [31:0] i_m10, i_m11, i_m12,
    input  logic [31:0] i_m20, i_m21, i_m22,
    output logic        o_valid,
    output logic [31:0] o_r00, o_r01, o_r02,
    output logic [31:0] o_r10, o_r11, o_r12,
    output logic [31:0] o_r20, o_r21, o_r22,
    output logic        o_singular,
    output logic        o_saturated
);

    logic [8:0][31:0] m, r;
    t_job job, head;
    logic push, pop, full, empty;

    assign m = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};

    m3inv_front u_front (
        .i_clk, .i_rst_n, .start, .busy, .i_m(m), .i_full(full),
        .o_push(push), .o_job(job)
    );

    m3inv_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_head(head)
    );

    m3inv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(head), .o_pop(pop),
        .o_valid, .o_r(r), .o_singular, .o_saturated
    );

    assign {o_r22, o_r21, o_r20, o_r12, o_r11, o_r10, o_r02, o_r01, o_r00} = r;

endmodule

### rtl/m3inv_front.sv
// Front end: accepts a matrix and forms the adjugate and determinant on one shared multiplier.
module m3inv_front
    import m3inv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [8:0][31:0]   i_m,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    t_fstate r_state, n_state;
    logic [4:0]          r_step;
    logic signed [31:0]  r_m [9];
    logic signed [CW-1:0] r_cof [9];
    logic signed [65:0]  r_p;
    t_op                 r_pctl;
    logic                r_pv;
    logic signed [DW:0]  r_acc;
    t_op                 op;
    logic signed [32:0]  a, b;
    logic signed [DW:0]  term, base, n_acc;
    logic signed [CW-1:0] cb;

    always_comb begin
        op = m3inv_op(r_step);
        a  = {r_m[op.a_idx][31], r_m[op.a_idx]};
        cb = r_cof[op.b_idx];
        unique case (op.b_kind)
            B_M:     b = {r_m[op.b_idx][31], r_m[op.b_idx]};
            B_LO:    b = {1'b0, cb[31:0]};
            B_HI:    b = cb[CW-1:32];
            default: b = '0;
        endcase
        term  = (r_pctl.b_kind == B_HI) ? {{2{r_p[65]}}, r_p, 32'b0} : {{34{r_p[65]}}, r_p};
        base  = r_pctl.first ? '0 : r_acc;
        n_acc = r_pctl.neg ? base - term : base + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE:  if (start) n_state = F_RUN;
            F_RUN:   if (r_step == LAST_STEP) n_state = F_DRAIN;
            F_DRAIN: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= (r_state == F_RUN);
            if (r_state == F_IDLE) begin
                r_step <= '0;
            end else if (r_state == F_RUN) begin
                r_step <= r_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && start) begin
            for (int i = 0; i < 9; i++) r_m[i] <= i_m[i];
        end
        r_p    <= a * b;
        r_pctl <= op;
        if (r_pv) begin
            r_acc <= n_acc;
            if (r_pctl.wr) r_cof[r_pctl.c_idx] <= n_acc[CW-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) o_job.cof[i] = r_cof[i];
        o_job.det = r_acc[DW-1:0];
    end

    assign busy = (r_state != F_IDLE);

endmodule

### rtl/m3inv_queue.sv
// Two-entry queue that carries computed jobs from the front end to the divider.
module m3inv_queue
    import m3inv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

endmodule

### rtl/m3inv_back.sv
// Back end: divides each adjugate entry by the determinant, one quotient bit per cycle.
module m3inv_back
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_valid,
    output logic [8:0][31:0]  o_r,
    output logic              o_singular,
    output logic              o_saturated
);

    localparam int NW = CW + 2 * FRAC_BITS;

    t_bstate r_state, n_state;
    logic [3:0]    r_idx;
    logic [5:0]    r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_md, r_rem;
    logic [QB-1:0] r_low, r_q;
    logic          r_neg, r_ovf;
    logic [31:0]   r_res [9];
    logic          r_sing, r_sat;
    logic [CW-1:0] c, mc;
    logic [DW-1:0] md;
    logic [DW:0]   t;
    logic [31:0]   limit;
    logic          det_zero, ovf;

    always_comb begin
        c        = i_job.cof[r_idx];
        mc       = c[CW-1] ? (~c + 1'b1) : c;
        md       = i_job.det[DW-1] ? (~i_job.det + 1'b1) : i_job.det;
        det_zero = (i_job.det == '0);
        ovf      = ({{(DW - NW + QB){1'b0}}, r_num[NW-1:QB]} >= r_md);
        t        = {r_rem, r_low[QB-1]};
        limit    = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            B_IDLE:  if (!i_empty) n_state = det_zero ? B_OUT : B_LOAD;
            B_LOAD:  n_state = B_CHK;
            B_CHK:   n_state = ovf ? B_FIN : B_DIV;
            B_DIV:   if (r_cnt == 6'(QB - 1)) n_state = B_FIN;
            B_FIN:   n_state = (r_idx == 4'd8) ? B_OUT : B_LOAD;
            B_OUT: begin
                o_pop   = 1'b1;
                o_valid = 1'b1;
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_idx  <= '0;
                r_sat  <= 1'b0;
                r_sing <= det_zero;
                if (det_zero) begin
                    for (int i = 0; i < 9; i++) r_res[i] <= '0;
                end
            end
            B_LOAD: begin
                r_num <= {{(2 * FRAC_BITS){1'b0}}, mc} << (2 * FRAC_BITS);
                r_md  <= md;
                r_neg <= c[CW-1] ^ i_job.det[DW-1];
            end
            B_CHK: begin
                r_ovf <= ovf;
                r_rem <= {{(DW - NW + QB){1'b0}}, r_num[NW-1:QB]};
                r_low <= r_num[QB-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            B_DIV: begin
                if (t >= {1'b0, r_md}) begin
                    r_rem <= DW'(t - {1'b0, r_md});
                    r_q   <= {r_q[QB-2:0], 1'b1};
                end else begin
                    r_rem <= t[DW-1:0];
                    r_q   <= {r_q[QB-2:0], 1'b0};
                end
                r_low <= {r_low[QB-2:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            B_FIN: begin
                if (r_ovf || r_q > {1'b0, limit}) begin
                    r_res[r_idx] <= limit;
                    r_sat        <= 1'b1;
                end else begin
                    r_res[r_idx] <= r_neg ? (32'd0 - r_q[31:0]) : r_q[31:0];
                end
                r_idx <= r_idx + 4'd1;
            end
            B_OUT: ;
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 9; i++) o_r[i] = r_res[i];
    end
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

endmodule

### rtl/m3inv_checker.sv
// Port-level checks of the matrix inverse, bound to the top level.
module m3inv_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_r00,
    input logic        o_singular,
    input logic        o_saturated
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy did not rise after an item");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated && o_r00 == 32'd0)
        else $error("singular result is not clean");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy) else $error("activity after reset");

endmodule

bind matrix3_inverse m3inv_props u_chk (.*);

### tb/sv/m3inv_checker.sv
// Checker for the 3x3 matrix inverse: predicts each inverse and compares the strobed results.
module m3inv_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_m [9],
    input  logic        o_valid,
    input  logic [31:0] o_r [9],
    input  logic        o_singular,
    input  logic        o_saturated,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [31:0] r [9];
        logic        singular;
        logic        saturated;
    } t_inverse;

    t_inverse inverse_q[$];

    function automatic logic signed [127:0] widen(input logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    function automatic t_inverse invert(input logic [31:0] mv [9]);
        logic signed [127:0] a [9];
        logic signed [127:0] adj [9];
        logic signed [127:0] det;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [31:0] lim;
        logic neg;
        t_inverse res;
        for (int i = 0; i < 9; i++) a[i] = widen(mv[i]);
        adj[0] = a[4] * a[8] - a[5] * a[7];
        adj[1] = a[2] * a[7] - a[1] * a[8];
        adj[2] = a[1] * a[5] - a[2] * a[4];
        adj[3] = a[5] * a[6] - a[3] * a[8];
        adj[4] = a[0] * a[8] - a[2] * a[6];
        adj[5] = a[2] * a[3] - a[0] * a[5];
        adj[6] = a[3] * a[7] - a[4] * a[6];
        adj[7] = a[1] * a[6] - a[0] * a[7];
        adj[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        res.singular = (det == 0);
        res.saturated = 1'b0;
        for (int i = 0; i < 9; i++) begin
            res.r[i] = '0;
            if (!res.singular) begin
                neg = adj[i][127] ^ det[127];
                num = adj[i][127] ? -adj[i] : adj[i];
                num = num << (2 * FRAC_BITS);
                den = det[127] ? -det : det;
                quo = num / den;
                lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                if (quo > {96'd0, lim}) begin
                    res.saturated = 1'b1;
                    res.r[i] = lim;
                end else begin
                    res.r[i] = neg ? -quo[31:0] : quo[31:0];
                end
            end
        end
        return res;
    endfunction

    assign pending = inverse_q.size();

    always @(posedge i_clk) begin
        t_inverse want;
        logic bad;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (start && !busy) inverse_q.push_back(invert(i_m));
            if (o_valid) begin
                if (inverse_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("Unexpected result at %0t", $time);
                end else begin
                    want = inverse_q.pop_front();
                    bad = (want.singular !== o_singular) || (want.saturated !== o_saturated);
                    for (int i = 0; i < 9; i++) if (want.r[i] !== o_r[i]) bad = 1'b1;
                    if (bad) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10) begin
                            $display("Mismatch at %0t: singular %b/%b saturated %b/%b",
                                     $time, want.singular, o_singular,
                                     want.saturated, o_saturated);
                            for (int i = 0; i < 9; i++)
                                $display("  r%0d expected %h got %h", i, want.r[i], o_r[i]);
                        end
                    end
                end
            end
        end
    end

endmodule

### tb/sv/tb_matrix3_inverse.sv
// Top of the 3x3 matrix inverse testbench: clock, reset, stimulus and verdict.
module tb_matrix3_inverse;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] m [9];
    logic        o_valid;
    logic [31:0] r [9];
    logic        o_singular;
    logic        o_saturated;
    int          fail_count;
    int          pending;

    always #5 i_clk = ~i_clk;

    initial for (int i = 0; i < 9; i++) m[i] = '0;

    matrix3_inverse DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_m00(m[0]), .i_m01(m[1]), .i_m02(m[2]),
        .i_m10(m[3]), .i_m11(m[4]), .i_m12(m[5]),
        .i_m20(m[6]), .i_m21(m[7]), .i_m22(m[8]),
        .o_valid(o_valid),
        .o_r00(r[0]), .o_r01(r[1]), .o_r02(r[2]),
        .o_r10(r[3]), .o_r11(r[4]), .o_r12(r[5]),
        .o_r20(r[6]), .o_r21(r[7]), .o_r22(r[8]),
        .o_singular(o_singular), .o_saturated(o_saturated)
    );

    m3inv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_m(m),
        .o_valid(o_valid), .o_r(r), .o_singular(o_singular),
        .o_saturated(o_saturated), .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
            5: return $urandom_range(0, 255) - 128;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_matrix(input logic [31:0] v [9]);
        @(negedge i_clk);
        m = v;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) n = 0;
        repeat (n) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] v [9];
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: identity, diagonal, zero, singular rows, extremes, tiny values.
        for (int t = 0; t < 16; t++) begin
            for (int i = 0; i < 9; i++) v[i] = '0;
            case (t)
                0: begin v[0] = 32'h1_0000; v[4] = 32'h1_0000; v[8] = 32'h1_0000; end
                1: begin v[0] = 32'h2_0000; v[4] = -32'sh4_0000; v[8] = 32'h8000; end
                2: ;
                3: for (int i = 0; i < 9; i++) v[i] = 32'h1_0000;
                4: for (int i = 0; i < 9; i++) v[i] = 32'h8000_0000;
                5: for (int i = 0; i < 9; i++) v[i] = 32'h7FFF_FFFF;
                6: begin v[0] = 1; v[4] = 1; v[8] = 1; end
                7: begin v[0] = 32'h8000_0000; v[4] = 32'h8000_0000; v[8] = 32'h8000_0000; end
                8: begin v[0] = 32'h7FFF_FFFF; v[4] = 32'h7FFF_FFFF; v[8] = 32'h7FFF_FFFF; end
                9: begin v[0] = 32'hFFFF_FFFF; v[4] = 32'h1_0000; v[8] = 32'h1_0000; end
                10: begin v[1] = 32'h1_0000; v[5] = 32'h1_0000; v[6] = 32'h1_0000; end
                11: begin
                    for (int i = 0; i < 9; i++) v[i] = $urandom();
                    v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
                end
                12: begin v[0] = 32'h8000_0000; v[4] = 32'h7FFF_FFFF; v[8] = 1; end
                13: for (int i = 0; i < 9; i++) v[i] = (i % 4 == 0) ? 32'hFFFF_0000 : 32'h1;
                14: for (int i = 0; i < 9; i++) v[i] = 32'hFFFF_FFFF;
                15: for (int i = 0; i < 9; i++) v[i] = 32'h5555_5555 << (i % 2);
            endcase
            send_matrix(v);
        end
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < 400; n++) begin
            for (int i = 0; i < 9; i++) v[i] = rand_entry();
            if ($urandom_range(0, 15) == 0) begin
                v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
            end
            send_matrix(v);
            if (n == 200) while (pending != 0) @(posedge i_clk);
            idle_gap();
        end
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/m3inv_pkg.sv
rtl/m3inv_front.sv
rtl/m3inv_queue.sv
rtl/m3inv_back.sv
rtl/matrix3_inverse.sv
rtl/m3inv_checker.sv
tb/sv/m3inv_checker.sv
tb/sv/tb_matrix3_inverse.sv
